// File: hdl/dit_pkg.sv
`timescale 1ns / 1ps

package dit_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int ID_W    = 32;
    localparam int LEN_W   = 16;
    localparam int CMD_W   = 2;

    localparam logic [CMD_W-1:0] CMD_CHECK     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR_ID  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR_ALL = 2'd2;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic             wr_en;
        logic             clr_all;
        logic [IDX_W-1:0] wr_addr;
        logic [ID_W-1:0]  wr_id;
        logic [LEN_W-1:0] wr_len;
        logic [IDX_W-1:0] rd_addr;
    } store_cmd_t;

endpackage

// File: hdl/dit_req_if.sv
`timescale 1ns / 1ps

interface dit_req_if
    import dit_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] cmd;
    logic [ID_W-1:0]  device_id;
    logic [LEN_W-1:0] msg_length;

    modport source (output valid, cmd, device_id, msg_length, input ready);
    modport sink   (input valid, cmd, device_id, msg_length, output ready);
    modport mon    (input valid, ready, cmd, device_id, msg_length);
endinterface

// File: hdl/dit_res_if.sv
`timescale 1ns / 1ps

interface dit_res_if
    import dit_pkg::*;
;
    logic             valid;
    logic             ready;
    logic             hit;
    logic [LEN_W-1:0] prev_length;
    logic             full_res;

    modport source (output valid, hit, prev_length, full_res, input ready);
    modport sink   (input valid, hit, prev_length, full_res, output ready);
    modport mon    (input valid, ready, hit, prev_length, full_res);
endinterface

// File: hdl/duplicate_id_table.sv
`timescale 1ns / 1ps

// Table of recently seen device ids, each kept with the message length first
// recorded for it. A request carries cmd (check and record, clear one id,
// clear all), the id and the length; each request yields exactly one
// response. Check and clear-by-id walk the slots one per cycle through a
// single compare unit against a registered memory read (a hit stops the
// walk early); clear-all and the unused command answer without a walk. The
// block returns to idle once the response is taken. When the table is full
// a new id is not stored and full_res is raised. No request is accepted
// while one is in work.

module duplicate_id_table
    import dit_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    dit_req_if.sink   req,
    dit_res_if.source res
);

    store_cmd_t       scmd;
    logic [ID_W-1:0]  rd_id;
    logic [LEN_W-1:0] rd_len;

    dit_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .res    (res),
        .scmd   (scmd),
        .rd_id  (rd_id),
        .rd_len (rd_len)
    );

    dit_store u_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .scmd   (scmd),
        .rd_id  (rd_id),
        .rd_len (rd_len)
    );

endmodule

// File: hdl/dit_store.sv
`timescale 1ns / 1ps

module dit_store
    import dit_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  store_cmd_t       scmd,
    output logic [ID_W-1:0]  rd_id,
    output logic [LEN_W-1:0] rd_len
);

    logic [ID_W-1:0]    id_mem  [ENTRIES];
    logic [LEN_W-1:0]   len_mem [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;
    logic [ID_W-1:0]    rd_id_reg;
    logic [LEN_W-1:0]   rd_len_reg;
    logic               rd_vld_reg;

    // never-written slots read as empty
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= valid_reg[scmd.rd_addr];
            if (scmd.clr_all)
            begin
                valid_reg <= '0;
            end
            else if (scmd.wr_en)
            begin
                valid_reg[scmd.wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (scmd.wr_en)
        begin
            id_mem[scmd.wr_addr]  <= scmd.wr_id;
            len_mem[scmd.wr_addr] <= scmd.wr_len;
        end
        rd_id_reg  <= id_mem[scmd.rd_addr];
        rd_len_reg <= len_mem[scmd.rd_addr];
    end

    assign rd_id  = rd_vld_reg ? rd_id_reg  : '0;
    assign rd_len = rd_vld_reg ? rd_len_reg : '0;

endmodule

// File: hdl/dit_ctrl.sv
`timescale 1ns / 1ps

module dit_ctrl
    import dit_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    dit_req_if.sink          req,
    dit_res_if.source        res,
    output store_cmd_t       scmd,
    input  logic [ID_W-1:0]  rd_id,
    input  logic [LEN_W-1:0] rd_len
);

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] last_reg, last_next;
    logic [CMD_W-1:0] cmd_reg, cmd_next;
    logic [ID_W-1:0]  id_reg, id_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             hit_reg, hit_next;
    logic [LEN_W-1:0] prev_reg, prev_next;
    logic             full_reg, full_next;

    logic req_acc;
    logic found;
    logic slot0_empty;
    logic scan_last;
    logic scan_end;

    assign req_acc     = req.valid && req.ready;
    assign found       = (rd_id == id_reg);
    assign slot0_empty = (cmd_reg == CMD_CHECK) && (idx_reg == '0) && (rd_id == '0);
    assign scan_last   = (idx_reg == LAST_IDX);
    assign scan_end    = slot0_empty || found || scan_last;

    assign req.ready       = (state_reg == ST_IDLE);
    assign res.valid       = (state_reg == ST_DONE);
    assign res.hit         = hit_reg;
    assign res.prev_length = prev_reg;
    assign res.full_res    = full_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_acc)
                begin
                    if ((req.cmd == CMD_CHECK) || (req.cmd == CMD_CLEAR_ID))
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (res.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        idx_next  = idx_reg;
        last_next = last_reg;
        cmd_next  = cmd_reg;
        id_next   = id_reg;
        len_next  = len_reg;
        hit_next  = hit_reg;
        prev_next = prev_reg;
        full_next = full_reg;

        scmd         = '0;
        scmd.wr_id   = id_reg;
        scmd.wr_len  = len_reg;
        scmd.wr_addr = idx_reg;
        // slot data arrives in the cycle after its address
        scmd.rd_addr = (state_reg == ST_SCAN) ? idx_reg + 1'b1 : '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_acc)
                begin
                    cmd_next  = req.cmd;
                    id_next   = req.device_id;
                    len_next  = req.msg_length;
                    idx_next  = '0;
                    hit_next  = 1'b0;
                    prev_next = '0;
                    full_next = 1'b0;
                    if (req.cmd == CMD_CLEAR_ALL)
                    begin
                        scmd.clr_all = 1'b1;
                        last_next    = '0;
                        hit_next     = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                idx_next = idx_reg + 1'b1;
                if (slot0_empty)
                begin
                    scmd.wr_en   = 1'b1;
                    scmd.wr_addr = '0;
                end
                else if (found)
                begin
                    hit_next = 1'b1;
                    if (cmd_reg == CMD_CHECK)
                    begin
                        prev_next = rd_len;
                    end
                    else
                    begin
                        scmd.wr_en  = 1'b1;
                        scmd.wr_id  = '0;
                        scmd.wr_len = '0;
                    end
                end
                else if (scan_last && (cmd_reg == CMD_CHECK))
                begin
                    if (last_reg == LAST_IDX)
                    begin
                        full_next = 1'b1;
                    end
                    else
                    begin
                        scmd.wr_en   = 1'b1;
                        scmd.wr_addr = last_reg + 1'b1;
                        last_next    = last_reg + 1'b1;
                    end
                end
            end
            ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            last_reg  <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            last_reg  <= last_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        id_reg   <= id_next;
        len_reg  <= len_next;
        hit_reg  <= hit_next;
        prev_reg <= prev_next;
        full_reg <= full_next;
    end

endmodule

// File: hdl/dit_checker.sv
`timescale 1ns / 1ps

module dit_checker
    import dit_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    dit_req_if.sink   req,
    dit_res_if.source res
);

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.ready |=> res.valid && $stable(res.hit)
            && $stable(res.prev_length) && $stable(res.full_res))
        else $error("response changed while stalled");

    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("request taken while another is in work");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> !req.ready)
        else $error("ready while a response is pending");

    a_clear_all: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready && (req.cmd == CMD_CLEAR_ALL)
            |=> res.valid && res.hit && (res.prev_length == '0) && !res.full_res)
        else $error("clear-all response wrong");

    a_miss_fields: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.hit |-> (res.prev_length == '0))
        else $error("length reported without a hit");

endmodule

bind duplicate_id_table dit_checker u_dit_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .res   (res)
);
